// ----- hdl/fsa_pkg.sv -----
// Shared types and constants of the segment allocator.
`timescale 1ns / 1ps
`default_nettype none
package fsa_pkg;

	localparam int OFF_W  = 16;
	localparam int HOLE_W = 7;
	localparam logic [OFF_W-1:0] RESET_POOL = 16'hFFFF;

	// request kinds
	localparam logic [1:0] FN_ALLOC  = 2'd0;
	localparam logic [1:0] FN_FREE   = 2'd1;
	localparam logic [1:0] FN_REINIT = 2'd2;

	// fit strategies
	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;
	localparam logic [1:0] FIT_NEXT  = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NO_FIT  = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_ZERO    = 3'd4;

	// register indexes
	localparam logic REG_FIT  = 1'b0;
	localparam logic REG_POOL = 1'b1;

	typedef struct packed {
		logic [OFF_W-1:0] start;
		logic [OFF_W-1:0] size;
		logic             used;
	} seg_t;

	localparam seg_t RESET_SEG = '{start: '0, size: RESET_POOL, used: 1'b0};

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_FIX1,
		S_FIX2,
		S_STATS,
		S_OUT
	} state_t;

endpackage
`default_nettype wire

// ----- hdl/fit_strategy_segment_allocator.sv -----
// Segment allocator: address-ordered segment table in one memory, walked by a sequencer.
//
// channel  direction  handshake                     payload
// s_*      in         s_tvalid / s_tready           s_tuser func, s_tdata size and offset
// m_*      out        m_tvalid / m_tready           m_tdata status and pool statistics
// apb      in         psel & penable & pwrite       fit strategy at 0x0, pool size at 0x4
//
// An allocate or free scans the table, shifts entries when a split or merge moves them,
// writes the fix-up entries and then walks the table again for the statistics.
// Allocate of zero and unused codes do only the statistics walk; reinit rewrites entry 0 first.
// Reset is asynchronous; entry 0 reads as one free full-size segment until first written.
// A stalled result holds in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none
module fit_strategy_segment_allocator #(
	parameter int MAX_SEGMENTS = 64
) (
	input  wire                    clk,
	input  wire                    arst_n,
	// request channel
	input  wire                    s_tvalid,
	output logic                   s_tready,
	input  wire  [31:0]            s_tdata,   // request_size[15:0], release_offset[31:16]
	input  wire  [1:0]             s_tuser,   // func[1:0]
	// result channel
	output logic                   m_tvalid,
	input  wire                    m_tready,
	output logic [79:0]            m_tdata,   // status[2:0], granted_offset[18:3],
	                                          // free_bytes[34:19], largest_free[50:35],
	                                          // hole_count[57:51], allocated_bytes[73:58], zero
	// configuration
	input  wire                    psel,
	input  wire                    penable,
	input  wire                    pwrite,
	input  wire  [2:0]             paddr,
	input  wire  [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import fsa_pkg::*;

	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

	state_t state_q, state_n;

	// configuration registers
	logic [1:0]       fit_q;
	logic [OFF_W-1:0] pool_q;
	logic             cfg_wr;

	// latched request
	logic [1:0]       func_q;
	logic [OFF_W-1:0] req_q, off_q;

	// table bookkeeping
	logic [CW-1:0] count_q;
	logic [IW-1:0] cursor_q;
	logic          e0_valid_q;

	// table memory and its read pipeline
	seg_t          mem [MAX_SEGMENTS];
	seg_t          rraw_s1, rd_s1;
	logic          rvalid_s1, rzero_s1;
	logic [IW-1:0] ridx_s1;
	logic          ren, we;
	logic [IW-1:0] raddr, waddr;
	seg_t          wdata;

	// walk counter
	logic [CW-1:0] k_q;
	logic [CW-1:0] scan_start;
	logic [CW:0]   scan_sum;
	logic          walk_done;

	// search results
	logic          found_q, next_got_q;
	logic [IW-1:0] fidx_q;
	seg_t          fent_q, last_q, prev_q, next_q;

	// shift engine
	logic [IW-1:0] sh_rd_q;
	logic [CW-1:0] sh_left_q;
	logic          sh_up_q;
	logic [1:0]    sh_dk_q;

	// fix-up writes
	logic [IW-1:0] w1_addr_q, w2_addr_q;
	seg_t          w1_q, w2_q;
	logic          w2_en_q;

	// decision
	logic [2:0]    d_status;
	logic [OFF_W-1:0] d_granted;
	logic          d_fix, d_w2_en, d_up;
	logic [1:0]    d_dk;
	logic [CW-1:0] d_left, d_count;
	logic [IW-1:0] d_rd, d_cursor, d_w1_addr, d_w2_addr;
	seg_t          d_w1, d_w2;
	logic          alloc_ok, pf, nf;
	logic [CW-1:0] bx;

	// result registers
	logic [2:0]       status_q;
	logic [OFF_W-1:0] granted_q;
	logic [OFF_W-1:0] sfree_q, sused_q, slarge_q;
	logic [CW-1:0]    sholes_q;

	logic accept;

	assign accept = s_tvalid && s_tready;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	// configuration read-back
	always_comb begin
		if (paddr[2] == REG_POOL) begin
			prdata = {{(32 - OFF_W){1'b0}}, pool_q};
		end else begin
			prdata = {30'b0, fit_q};
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q  <= FIT_FIRST;
			pool_q <= RESET_POOL;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_FIT) begin
				fit_q <= pwdata[1:0];
			end else begin
				pool_q <= pwdata[OFF_W-1:0];
			end
		end
	end

	// walk addressing: next fit walks circularly from the cursor
	always_comb begin
		if (func_q == FN_ALLOC && fit_q == FIT_NEXT) begin
			scan_start = CW'(cursor_q);
		end else begin
			scan_start = '0;
		end
		scan_sum = {1'b0, scan_start} + {1'b0, k_q};
		if (scan_sum >= {1'b0, count_q}) begin
			scan_sum = scan_sum - {1'b0, count_q};
		end
		walk_done = (k_q == count_q) && !rvalid_s1;
	end

	// memory port control
	always_comb begin
		ren   = 1'b0;
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = rd_s1;
		case (state_q)
			S_SCAN: begin
				ren   = k_q < count_q;
				raddr = IW'(scan_sum);
			end
			S_STATS: begin
				ren   = k_q < count_q;
				raddr = IW'(k_q);
			end
			S_SHIFT: begin
				ren   = sh_left_q != '0;
				raddr = sh_rd_q;
				we    = rvalid_s1;
				waddr = sh_up_q ? ridx_s1 + IW'(1) : ridx_s1 - IW'(sh_dk_q);
			end
			S_FIX1: begin
				we    = 1'b1;
				waddr = w1_addr_q;
				wdata = w1_q;
			end
			S_FIX2: begin
				we    = w2_en_q;
				waddr = w2_addr_q;
				wdata = w2_q;
			end
			default: begin
				ren = 1'b0;
			end
		endcase
	end

	// table memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rraw_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_s1  <= 1'b0;
			rzero_s1   <= 1'b0;
			ridx_s1    <= '0;
			e0_valid_q <= 1'b0;
		end else begin
			rvalid_s1 <= ren;
			if (ren) begin
				ridx_s1  <= raddr;
				rzero_s1 <= (raddr == '0) && !e0_valid_q;
			end
			if (we && waddr == '0) begin
				e0_valid_q <= 1'b1;
			end
		end
	end

	// entry 0 reads as the reset segment until first written
	assign rd_s1 = rzero_s1 ? RESET_SEG : rraw_s1;

	// decide the outcome of the request
	always_comb begin
		bx        = CW'(fidx_q);
		alloc_ok  = found_q && (fit_q != FIT_WORST || fent_q.size >= req_q);
		pf        = (fidx_q != '0) && !prev_q.used;
		nf        = (bx + CW'(1) < count_q) && next_got_q && !next_q.used;
		d_status  = ST_OK;
		d_granted = '0;
		d_fix     = 1'b0;
		d_w2_en   = 1'b0;
		d_up      = 1'b0;
		d_dk      = 2'd1;
		d_left    = '0;
		d_rd      = '0;
		d_count   = count_q;
		d_cursor  = cursor_q;
		d_w1_addr = fidx_q;
		d_w2_addr = fidx_q;
		d_w1      = fent_q;
		d_w2      = fent_q;
		case (func_q)
			FN_ALLOC: begin
				if (req_q == '0) begin
					d_status = ST_ZERO;
				end else if (!alloc_ok) begin
					d_status = ST_NO_FIT;
				end else if (fent_q.size > req_q) begin
					if (count_q >= MAX_CNT) begin
						d_status = ST_FULL;
					end else begin
						// open a slot after the chosen entry, then split
						d_granted = fent_q.start;
						d_fix     = 1'b1;
						d_up      = 1'b1;
						d_left    = count_q - CW'(1) - bx;
						d_rd      = IW'(count_q - CW'(1));
						d_w1_addr = fidx_q + IW'(1);
						d_w1      = '{start: fent_q.start + req_q,
						              size: fent_q.size - req_q, used: 1'b0};
						d_w2_en   = 1'b1;
						d_w2      = '{start: fent_q.start, size: req_q, used: 1'b1};
						d_count   = count_q + CW'(1);
						d_cursor  = fidx_q + IW'(1);
					end
				end else begin
					d_granted = fent_q.start;
					d_fix     = 1'b1;
					d_w1      = '{start: fent_q.start, size: fent_q.size, used: 1'b1};
					d_cursor  = (bx + CW'(1) < count_q) ? fidx_q + IW'(1) : '0;
				end
			end
			FN_FREE: begin
				if (!found_q) begin
					d_status = ST_UNKNOWN;
				end else begin
					d_fix = 1'b1;
					if (pf && nf) begin
						d_w1_addr = fidx_q - IW'(1);
						d_w1      = '{start: prev_q.start,
						              size: prev_q.size + fent_q.size + next_q.size,
						              used: 1'b0};
						d_dk      = 2'd2;
						d_rd      = fidx_q + IW'(2);
						d_left    = count_q - bx - CW'(2);
						d_count   = count_q - CW'(2);
						d_cursor  = cursor_q;
						if (d_cursor >= fidx_q) begin
							d_cursor = d_cursor - IW'(1);
						end
						if (d_cursor >= fidx_q) begin
							d_cursor = d_cursor - IW'(1);
						end
					end else if (pf) begin
						d_w1_addr = fidx_q - IW'(1);
						d_w1      = '{start: prev_q.start, size: prev_q.size + fent_q.size,
						              used: 1'b0};
						d_rd      = fidx_q + IW'(1);
						d_left    = count_q - bx - CW'(1);
						d_count   = count_q - CW'(1);
						if (cursor_q >= fidx_q) begin
							d_cursor = cursor_q - IW'(1);
						end
					end else if (nf) begin
						d_w1      = '{start: fent_q.start, size: fent_q.size + next_q.size,
						              used: 1'b0};
						d_rd      = fidx_q + IW'(2);
						d_left    = count_q - bx - CW'(2);
						d_count   = count_q - CW'(1);
						if (cursor_q > fidx_q) begin
							d_cursor = cursor_q - IW'(1);
						end
					end else begin
						d_w1 = '{start: fent_q.start, size: fent_q.size, used: 1'b0};
					end
				end
			end
			FN_REINIT: begin
				d_fix     = 1'b1;
				d_w1_addr = '0;
				d_w1      = '{start: '0, size: pool_q, used: 1'b0};
				d_count   = CW'(1);
				d_cursor  = '0;
			end
			default: begin
				d_status = ST_OK;
			end
		endcase
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if ((s_tuser == FN_ALLOC && s_tdata[OFF_W-1:0] != '0) ||
					    s_tuser == FN_FREE) begin
						state_n = S_SCAN;
					end else begin
						state_n = S_DECIDE;
					end
				end
			end
			S_SCAN: begin
				if (walk_done) begin
					state_n = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (d_left != '0) begin
					state_n = S_SHIFT;
				end else if (d_fix) begin
					state_n = S_FIX1;
				end else begin
					state_n = S_STATS;
				end
			end
			S_SHIFT: begin
				if (sh_left_q == '0 && !rvalid_s1) begin
					state_n = S_FIX1;
				end
			end
			S_FIX1: begin
				state_n = w2_en_q ? S_FIX2 : S_STATS;
			end
			S_FIX2: begin
				state_n = S_STATS;
			end
			S_STATS: begin
				if (walk_done) begin
					state_n = S_OUT;
				end
			end
			S_OUT: begin
				if (!m_tvalid || m_tready) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// handshake outputs
	always_comb begin
		s_tready = (state_q == S_IDLE);
	end

	// sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= CW'(1);
			cursor_q   <= '0;
			k_q        <= '0;
			found_q    <= 1'b0;
			next_got_q <= 1'b0;
			sh_left_q  <= '0;
			w2_en_q    <= 1'b0;
			m_tvalid   <= 1'b0;
		end else begin
			state_q <= state_n;

			// advance the walk counter
			if (ren && (state_q == S_SCAN || state_q == S_STATS)) begin
				k_q <= k_q + CW'(1);
			end else if (state_q != S_SCAN && state_q != S_STATS) begin
				k_q <= '0;
			end

			// raise valid on a new result, drop it once taken
			if (state_q == S_OUT && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q     <= s_tuser;
						req_q      <= s_tdata[OFF_W-1:0];
						off_q      <= s_tdata[2*OFF_W-1:OFF_W];
						found_q    <= 1'b0;
						next_got_q <= 1'b0;
						last_q     <= RESET_SEG;
						prev_q     <= RESET_SEG;
						next_q     <= RESET_SEG;
						fent_q     <= RESET_SEG;
						fidx_q     <= '0;
						// next fit restarts from the first entry if the cursor is stale
						if (s_tuser == FN_ALLOC && s_tdata[OFF_W-1:0] != '0 &&
						    fit_q == FIT_NEXT && CW'(cursor_q) >= count_q) begin
							cursor_q <= '0;
						end
					end
				end
				S_SCAN: begin
					if (rvalid_s1) begin
						last_q <= rd_s1;
						if (func_q == FN_ALLOC) begin
							if (fit_q == FIT_BEST) begin
								if (!rd_s1.used && rd_s1.size >= req_q &&
								    (!found_q || rd_s1.size < fent_q.size)) begin
									found_q <= 1'b1;
									fidx_q  <= ridx_s1;
									fent_q  <= rd_s1;
								end
							end else if (fit_q == FIT_WORST) begin
								if (!rd_s1.used && (!found_q || rd_s1.size > fent_q.size)) begin
									found_q <= 1'b1;
									fidx_q  <= ridx_s1;
									fent_q  <= rd_s1;
								end
							end else begin
								if (!rd_s1.used && rd_s1.size >= req_q && !found_q) begin
									found_q <= 1'b1;
									fidx_q  <= ridx_s1;
									fent_q  <= rd_s1;
								end
							end
						end else begin
							// free: find the used segment, keep both neighbors
							if (!found_q && rd_s1.used && rd_s1.start == off_q) begin
								found_q <= 1'b1;
								fidx_q  <= ridx_s1;
								fent_q  <= rd_s1;
								prev_q  <= last_q;
							end
							if (found_q && !next_got_q && ridx_s1 == fidx_q + IW'(1)) begin
								next_q     <= rd_s1;
								next_got_q <= 1'b1;
							end
						end
					end
				end
				S_DECIDE: begin
					status_q  <= d_status;
					granted_q <= d_granted;
					count_q   <= d_count;
					cursor_q  <= d_cursor;
					sh_left_q <= d_left;
					sh_rd_q   <= d_rd;
					sh_up_q   <= d_up;
					sh_dk_q   <= d_dk;
					w1_addr_q <= d_w1_addr;
					w2_addr_q <= d_w2_addr;
					w1_q      <= d_w1;
					w2_q      <= d_w2;
					w2_en_q   <= d_w2_en;
					sfree_q   <= '0;
					sused_q   <= '0;
					slarge_q  <= '0;
					sholes_q  <= '0;
				end
				S_SHIFT: begin
					if (ren) begin
						sh_left_q <= sh_left_q - CW'(1);
						sh_rd_q   <= sh_up_q ? sh_rd_q - IW'(1) : sh_rd_q + IW'(1);
					end
				end
				S_STATS: begin
					if (rvalid_s1) begin
						if (rd_s1.used) begin
							sused_q <= sused_q + rd_s1.size;
						end else begin
							sfree_q  <= sfree_q + rd_s1.size;
							sholes_q <= sholes_q + CW'(1);
							if (rd_s1.size > slarge_q) begin
								slarge_q <= rd_s1.size;
							end
						end
					end
				end
				S_OUT: begin
					// load the result once the output register is free
					if (!m_tvalid || m_tready) begin
						m_tdata <= {6'b0, sused_q, HOLE_W'(sholes_q), slarge_q, sfree_q,
						            granted_q, status_q};
					end
				end
				default: begin
					w2_en_q <= w2_en_q;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && count_q <= MAX_CNT)
		else $error("segment count out of range");

	a_cursor_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> CW'(cursor_q) < count_q)
		else $error("cursor beyond table");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("request accepted without starting work");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_OUT))
		else $error("result loaded outside output stage");
`endif

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for the segment allocator: request stream, result stream, APB setup.
`timescale 1ns / 1ps
import fsa_pkg::*;

typedef struct packed {
	logic [2:0]  status;
	logic [15:0] granted;
	logic [15:0] free_b;
	logic [15:0] largest;
	logic [6:0]  holes;
	logic [15:0] used_b;
} pool_report_t;

class pool_scoreboard;
	localparam int NSEG = 64;
	logic [15:0] base [NSEG];
	logic [15:0] len [NSEG];
	bit busy [NSEG];
	int count;
	int cursor;
	logic [1:0] strategy;
	logic [15:0] pool_size;
	pool_report_t pending [$];
	int errors;

	function new();
		strategy = FIT_FIRST;
		pool_size = RESET_POOL;
		errors = 0;
		restart();
	endfunction

	function void restart();
		for (int i = 0; i < NSEG; i++) begin
			base[i] = '0;
			len[i] = '0;
			busy[i] = 0;
		end
		len[0] = pool_size;
		count = 1;
		cursor = 0;
	endfunction

	// close the gap at r after r was merged into r-1
	function void remove_at(int r);
		for (int i = r; i + 1 < count; i++) begin
			base[i] = base[i+1];
			len[i] = len[i+1];
			busy[i] = busy[i+1];
		end
		count--;
		base[count] = '0;
		len[count] = '0;
		busy[count] = 0;
		if (cursor >= r)
			cursor--;
	endfunction

	function int choose(logic [15:0] req);
		int hit;
		int i;
		hit = -1;
		case (strategy)
			FIT_FIRST: begin
				for (i = 0; i < count; i++)
					if (!busy[i] && len[i] >= req)
						return i;
			end
			FIT_BEST: begin
				for (i = 0; i < count; i++)
					if (!busy[i] && len[i] >= req && (hit < 0 || len[i] < len[hit]))
						hit = i;
			end
			FIT_WORST: begin
				for (i = 0; i < count; i++)
					if (!busy[i] && (hit < 0 || len[i] > len[hit]))
						hit = i;
				if (hit >= 0 && len[hit] < req)
					hit = -1;
			end
			default: begin
				if (cursor >= count)
					cursor = 0;
				for (int k = 0; k < count; k++) begin
					i = (cursor + k) % count;
					if (!busy[i] && len[i] >= req)
						return i;
				end
			end
		endcase
		return hit;
	endfunction

	function logic [2:0] allocate(logic [15:0] req, output logic [15:0] granted);
		int b;
		granted = '0;
		if (req == 0)
			return ST_ZERO;
		b = choose(req);
		if (b < 0)
			return ST_NO_FIT;
		if (len[b] > req) begin
			if (count >= NSEG)
				return ST_FULL;
			for (int i = count; i > b + 1; i--) begin
				base[i] = base[i-1];
				len[i] = len[i-1];
				busy[i] = busy[i-1];
			end
			count++;
			base[b+1] = base[b] + req;
			len[b+1] = len[b] - req;
			busy[b+1] = 0;
			len[b] = req;
			cursor = b + 1;
		end else begin
			cursor = (b + 1 < count) ? b + 1 : 0;
		end
		busy[b] = 1;
		granted = base[b];
		return ST_OK;
	endfunction

	function logic [2:0] release_at(logic [15:0] off);
		int b;
		b = -1;
		for (int i = 0; i < count; i++)
			if (busy[i] && base[i] == off) begin
				b = i;
				break;
			end
		if (b < 0)
			return ST_UNKNOWN;
		busy[b] = 0;
		if (b > 0 && !busy[b-1]) begin
			len[b-1] += len[b];
			remove_at(b);
			b--;
		end
		if (b + 1 < count && !busy[b+1]) begin
			len[b] += len[b+1];
			remove_at(b + 1);
		end
		return ST_OK;
	endfunction

	// note an accepted request and queue its result
	function void note_request(logic [1:0] fn, logic [15:0] req, logic [15:0] off);
		pool_report_t r;
		logic [15:0] g;
		int total;
		int fr;
		int big;
		int nh;
		g = '0;
		r.status = ST_OK;
		if (fn == FN_ALLOC)
			r.status = allocate(req, g);
		else if (fn == FN_FREE)
			r.status = release_at(off);
		else if (fn == FN_REINIT)
			restart();
		total = 0; fr = 0; big = 0; nh = 0;
		for (int i = 0; i < count; i++) begin
			total += len[i];
			if (!busy[i]) begin
				fr += len[i];
				nh++;
				if (len[i] > big)
					big = len[i];
			end
		end
		r.granted = g;
		r.free_b = fr[15:0];
		r.largest = big[15:0];
		r.holes = nh[6:0];
		r.used_b = 16'(total - fr);
		pending.push_back(r);
	endfunction

	// return a used segment start, or a random offset when none
	function logic [15:0] some_used_start();
		int n;
		n = 0;
		for (int i = 0; i < count; i++)
			if (busy[i])
				n++;
		if (n == 0)
			return 16'($urandom);
		n = $urandom_range(n - 1, 0);
		for (int i = 0; i < count; i++)
			if (busy[i]) begin
				if (n == 0)
					return base[i];
				n--;
			end
		return '0;
	endfunction

	function void check_result(logic [79:0] d);
		pool_report_t e;
		if (pending.size() == 0) begin
			$error("result with nothing pending: %h", d);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (d[2:0] != e.status) begin
			$error("status exp %0d got %0d", e.status, d[2:0]); errors++;
		end
		if (d[18:3] != e.granted) begin
			$error("granted_offset exp %0d got %0d", e.granted, d[18:3]); errors++;
		end
		if (d[34:19] != e.free_b) begin
			$error("free_bytes exp %0d got %0d", e.free_b, d[34:19]); errors++;
		end
		if (d[50:35] != e.largest) begin
			$error("largest_free exp %0d got %0d", e.largest, d[50:35]); errors++;
		end
		if (d[57:51] != e.holes) begin
			$error("hole_count exp %0d got %0d", e.holes, d[57:51]); errors++;
		end
		if (d[73:58] != e.used_b) begin
			$error("allocated_bytes exp %0d got %0d", e.used_b, d[73:58]); errors++;
		end
	endfunction
endclass

module testbench;
	localparam int LIMIT = 1500000;
	localparam int DRAIN = 300;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [79:0] m_tdata;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	pool_scoreboard board;
	int cycles;
	bit calm;
	bit hold_off;

	fit_strategy_segment_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// count cycles and stop on timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: random stall, long hold-off when asked
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_result(m_tdata);
			m_tready <= !hold_off && (calm || $urandom_range(99, 0) >= 19);
		end
	end

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (addr == 3'd0)
			board.strategy = val[1:0];
		else
			board.pool_size = val[15:0];
		@(posedge clk);
	endtask

	// offer one request, with a random gap before it
	task automatic send(input logic [1:0] fn, input logic [15:0] req, input logic [15:0] off);
		while (!calm && $urandom_range(99, 0) < 19)
			@(posedge clk);
		s_tvalid <= 1; s_tuser <= fn; s_tdata <= {off, req};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_request(fn, req, off);
		s_tvalid <= 0;
		@(posedge clk);
	endtask

	task automatic settle();
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic random_phase(input int n, input int span);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99, 0);
			if (pick < 50)
				send(FN_ALLOC, 16'($urandom_range(span, 1)), 16'($urandom));
			else if (pick < 85)
				send(FN_FREE, 16'($urandom), board.some_used_start());
			else if (pick < 92)
				send(FN_FREE, 16'($urandom), 16'($urandom));
			else if (pick < 95)
				send(FN_ALLOC, 16'($urandom), 16'($urandom));
			else if (pick < 97)
				send(FN_REINIT, 16'($urandom), 16'($urandom));
			else if (pick < 98)
				send(2'd3, 16'($urandom), 16'($urandom));
			else
				send(FN_ALLOC, 16'h0000, 16'($urandom));
		end
	endtask

	initial begin
		board = new();
		cycles = 0; calm = 0; hold_off = 0;
		arst_n = 0;
		s_tvalid = 0; s_tdata = '0; s_tuser = '0; m_tready = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, zero size, unknown offset, unused code
		send(FN_ALLOC, 16'h0000, 16'h0000);
		send(FN_ALLOC, 16'hFFFF, 16'h0000);
		send(FN_REINIT, 16'h0000, 16'hFFFF);
		send(FN_ALLOC, 16'h0001, 16'hFFFF);
		send(FN_ALLOC, 16'h0100, 16'h0000);
		send(FN_ALLOC, 16'hFFFF, 16'h0000);
		send(FN_FREE, 16'hFFFF, 16'h0001);
		send(FN_FREE, 16'h0000, 16'h0101);
		send(FN_FREE, 16'h0000, 16'h0000);
		send(FN_FREE, 16'h0000, 16'h0001);
		send(2'd3, 16'hFFFF, 16'hFFFF);
		settle();

		// empty pool, then an exact fit of a tiny pool
		write_reg(3'd4, 32'd0);
		send(FN_REINIT, 16'h0000, 16'h0000);
		send(FN_ALLOC, 16'h0001, 16'h0000);
		settle();
		write_reg(3'd4, 32'd1);
		send(FN_REINIT, 16'h0000, 16'h0000);
		send(FN_ALLOC, 16'h0001, 16'h0000);
		send(FN_FREE, 16'h0000, 16'h0000);
		settle();

		// table full: fill with small splits, then try one more split
		write_reg(3'd4, 32'd1000);
		send(FN_REINIT, 16'h0000, 16'h0000);
		calm = 1;
		for (int i = 0; i < 64; i++)
			send(FN_ALLOC, 16'd3, 16'h0000);
		calm = 0;
		send(FN_ALLOC, 16'd1, 16'h0000);
		settle();

		// receiver holds off while requests keep coming
		fork
			begin
				hold_off = 1;
				repeat (3000) @(posedge clk);
				hold_off = 0;
			end
			random_phase(12, 200);
		join
		settle();

		// each strategy, with pool sizes from small to the maximum
		for (int s = 0; s < 4; s++) begin
			write_reg(3'd0, 32'(s));
			write_reg(3'd4, (s == 3) ? 32'hFFFF : 32'($urandom_range(4000, 200)));
			send(FN_REINIT, 16'h0000, 16'h0000);
			if (s == 2)
				calm = 1;
			random_phase(90, (s == 3) ? 8000 : 400);
			calm = 0;
			settle();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// ----- sim.f -----
hdl/fsa_pkg.sv
hdl/fit_strategy_segment_allocator.sv
bench/testbench.sv
